// ----- sv/cpr_pkg.sv -----
// Shared types, codes and constants of the code-point range-set engine.
package cpr_pkg;

    localparam int CP_W            = 21;
    localparam int HELD_W          = 6;
    localparam int FUNC_W          = 3;
    localparam int MAX_RANGES_DEF  = 32;

    localparam logic [CP_W-1:0] CP_TOP = 21'h10FFFF;

    localparam logic [FUNC_W-1:0] FUNC_APPEND     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_NORMALIZE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPLEMENT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
    } span_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CP_W-1:0]   range_start;
        logic [CP_W-1:0]   range_end;
        logic [CP_W-1:0]   query_point;
    } in_word_t;

    typedef struct packed {
        logic              status;
        logic              found;
        logic [HELD_W-1:0] ranges_held;
    } out_word_t;

endpackage

// ----- sv/cpr_store.sv -----
// Range store memory with one write port and one registered read port.
module cpr_store import cpr_pkg::*; #(
    parameter int DEPTH = MAX_RANGES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  span_t         wdata,
    input  logic [AW-1:0] raddr,
    output span_t         rdata
);

    span_t mem [DEPTH];
    span_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/code_point_range_set_engine_top.sv -----
// Top level of the code-point range-set engine: sequencer around the range store.
//
//   channel | direction | ports                      | word
//   s_      | in        | s_valid, s_ready, s_data   | in_word_t
//   m_      | out       | m_valid, m_ready, m_data   | out_word_t
//
// One word is in work at a time. Append, clear and refused operations go from idle straight to the result.
// A query is a binary search; each probe is a read state and a compare state through the store's read port.
// Normalize runs stable bubble passes until a pass makes no swap, then a merge pass;
// complement adds two more passes, one that counts the gaps and one that writes them.
// Reset is synchronous and clears the count and the failed flag; the store holds no reset.
// A stalled result waits in the output register; the next word is taken once it is loaded.
module code_point_range_set_engine_top import cpr_pkg::*; #(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int AW    = $clog2(MAX_RANGES);
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int NW    = $clog2(MAX_RANGES + 2);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SORT_RD, ST_SORT_EX, ST_SORT_END, ST_MERGE_RD, ST_MERGE_EX,
        ST_MERGE_END, ST_POST, ST_CMP_RD, ST_CMP_EX, ST_CMP_END, ST_GAP_RD,
        ST_GAP_EX, ST_GAP_END, ST_Q_RD, ST_Q_EX
    } state_t;

    state_t           state_reg, state_next;
    logic             finish_reg, finish_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] low_reg, low_next;
    logic [CNT_W-1:0] high_reg, high_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [CP_W-1:0]  nxt_reg, nxt_next;
    logic [CP_W-1:0]  qp_reg, qp_next;
    span_t            carry_reg, carry_next;
    logic             failed_reg, failed_next;
    logic             swap_reg, swap_next;
    logic             open_reg, open_next;
    logic             comp_reg, comp_next;
    logic             st_reg, st_next;
    logic             fnd_reg, fnd_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        m_data_reg, m_data_next;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    span_t            wdata, rdata;
    logic [CNT_W-1:0] idx_inc, idx_dec, used_dec, cnt_dec, mid_calc;
    logic [NW-1:0]    n_total;
    logic             last_elem;

    cpr_store #(.DEPTH(MAX_RANGES), .AW(AW)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign used_dec  = used_reg - 1'b1;
    assign cnt_dec   = cnt_reg - 1'b1;
    assign last_elem = (idx_inc == cnt_reg);
    assign mid_calc  = low_reg + ((high_reg - low_reg) >> 1);
    assign n_total   = n_reg + NW'(open_reg);

    always_comb begin
        state_next   = state_reg;
        finish_next  = finish_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        used_next    = used_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        mid_next     = mid_reg;
        n_next       = n_reg;
        nxt_next     = nxt_reg;
        qp_next      = qp_reg;
        carry_next   = carry_reg;
        failed_next  = failed_reg;
        swap_next    = swap_reg;
        open_next    = open_reg;
        comp_next    = comp_reg;
        st_next      = st_reg;
        fnd_next     = fnd_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        we           = 1'b0;
        waddr        = '0;
        wdata        = carry_reg;
        raddr        = idx_reg[AW-1:0];

        if (finish_reg) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_next            = 1'b1;
                m_data_next.status      = st_reg;
                m_data_next.found       = fnd_reg;
                m_data_next.ranges_held = HELD_W'(cnt_reg);
                finish_next             = 1'b0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        st_next   = 1'b0;
                        fnd_next  = 1'b0;
                        idx_next  = '0;
                        swap_next = 1'b0;
                        qp_next   = s_data.query_point;
                        comp_next = (s_data.func == FUNC_COMPLEMENT);
                        case (s_data.func)
                            FUNC_APPEND: begin
                                finish_next = 1'b1;
                                if (failed_reg) begin
                                    st_next = 1'b1;
                                end else if (cnt_reg >= CNT_W'(MAX_RANGES)) begin
                                    failed_next = 1'b1;
                                    st_next     = 1'b1;
                                end else begin
                                    we       = 1'b1;
                                    waddr    = cnt_reg[AW-1:0];
                                    wdata    = '{lo: s_data.range_start, hi: s_data.range_end};
                                    cnt_next = cnt_reg + 1'b1;
                                end
                            end
                            FUNC_NORMALIZE, FUNC_COMPLEMENT: begin
                                if (failed_reg) begin
                                    st_next     = 1'b1;
                                    finish_next = 1'b1;
                                end else if (cnt_reg == '0) begin
                                    state_next = ST_POST;
                                end else if (cnt_reg == CNT_W'(1)) begin
                                    state_next = ST_MERGE_RD;
                                end else begin
                                    state_next = ST_SORT_RD;
                                end
                            end
                            FUNC_QUERY: begin
                                low_next   = '0;
                                high_next  = cnt_reg;
                                state_next = ST_Q_RD;
                            end
                            FUNC_CLEAR: begin
                                cnt_next    = '0;
                                failed_next = 1'b0;
                                finish_next = 1'b1;
                            end
                            default: begin
                                finish_next = 1'b1;
                            end
                        endcase
                    end
                end
                ST_SORT_RD: begin
                    state_next = ST_SORT_EX;
                end
                ST_SORT_EX: begin
                    if (idx_reg == '0) begin
                        carry_next = rdata;
                    end else if (carry_reg.lo > rdata.lo) begin
                        we        = 1'b1;
                        waddr     = idx_dec[AW-1:0];
                        wdata     = rdata;
                        swap_next = 1'b1;
                    end else begin
                        we         = 1'b1;
                        waddr      = idx_dec[AW-1:0];
                        carry_next = rdata;
                    end
                    idx_next   = idx_inc;
                    state_next = last_elem ? ST_SORT_END : ST_SORT_RD;
                end
                ST_SORT_END: begin
                    we         = 1'b1;
                    waddr      = cnt_dec[AW-1:0];
                    idx_next   = '0;
                    swap_next  = 1'b0;
                    state_next = swap_reg ? ST_SORT_RD : ST_MERGE_RD;
                end
                ST_MERGE_RD: begin
                    state_next = ST_MERGE_EX;
                end
                ST_MERGE_EX: begin
                    if (idx_reg == '0) begin
                        carry_next = rdata;
                        used_next  = CNT_W'(1);
                    end else if ({1'b0, rdata.lo} <= {1'b0, carry_reg.hi} + 1'b1) begin
                        if (rdata.hi > carry_reg.hi) begin
                            carry_next.hi = rdata.hi;
                        end
                    end else begin
                        we         = 1'b1;
                        waddr      = used_dec[AW-1:0];
                        carry_next = rdata;
                        used_next  = used_reg + 1'b1;
                    end
                    idx_next   = idx_inc;
                    state_next = last_elem ? ST_MERGE_END : ST_MERGE_RD;
                end
                ST_MERGE_END: begin
                    we         = 1'b1;
                    waddr      = used_dec[AW-1:0];
                    cnt_next   = used_reg;
                    state_next = ST_POST;
                end
                ST_POST: begin
                    idx_next  = '0;
                    n_next    = '0;
                    nxt_next  = '0;
                    open_next = 1'b1;
                    if (!comp_reg) begin
                        state_next  = ST_IDLE;
                        finish_next = 1'b1;
                    end else begin
                        state_next = (cnt_reg == '0) ? ST_CMP_END : ST_CMP_RD;
                    end
                end
                ST_CMP_RD, ST_GAP_RD: begin
                    state_next = (state_reg == ST_CMP_RD) ? ST_CMP_EX : ST_GAP_EX;
                end
                ST_CMP_EX, ST_GAP_EX: begin
                    if (rdata.lo > nxt_reg) begin
                        n_next = n_reg + 1'b1;
                        if (state_reg == ST_GAP_EX) begin
                            we    = 1'b1;
                            waddr = n_reg[AW-1:0];
                            wdata = '{lo: nxt_reg, hi: rdata.lo - 1'b1};
                        end
                    end
                    idx_next = idx_inc;
                    if (rdata.hi >= CP_TOP) begin
                        open_next = 1'b0;
                    end else begin
                        nxt_next = rdata.hi + 1'b1;
                    end
                    if (rdata.hi >= CP_TOP || last_elem) begin
                        state_next = (state_reg == ST_CMP_EX) ? ST_CMP_END : ST_GAP_END;
                    end else begin
                        state_next = (state_reg == ST_CMP_EX) ? ST_CMP_RD : ST_GAP_RD;
                    end
                end
                ST_CMP_END: begin
                    if (n_total > NW'(MAX_RANGES)) begin
                        failed_next = 1'b1;
                        st_next     = 1'b1;
                        state_next  = ST_IDLE;
                        finish_next = 1'b1;
                    end else begin
                        idx_next   = '0;
                        n_next     = '0;
                        nxt_next   = '0;
                        open_next  = 1'b1;
                        state_next = (cnt_reg == '0) ? ST_GAP_END : ST_GAP_RD;
                    end
                end
                ST_GAP_END: begin
                    if (open_reg) begin
                        we    = 1'b1;
                        waddr = n_reg[AW-1:0];
                        wdata = '{lo: nxt_reg, hi: CP_TOP};
                    end
                    cnt_next    = CNT_W'(n_total);
                    state_next  = ST_IDLE;
                    finish_next = 1'b1;
                end
                ST_Q_RD: begin
                    if (low_reg >= high_reg) begin
                        state_next  = ST_IDLE;
                        finish_next = 1'b1;
                    end else begin
                        raddr      = mid_calc[AW-1:0];
                        mid_next   = mid_calc;
                        state_next = ST_Q_EX;
                    end
                end
                ST_Q_EX: begin
                    if (qp_reg < rdata.lo) begin
                        high_next  = mid_reg;
                        state_next = ST_Q_RD;
                    end else if (qp_reg > rdata.hi) begin
                        low_next   = mid_reg + 1'b1;
                        state_next = ST_Q_RD;
                    end else begin
                        fnd_next    = 1'b1;
                        state_next  = ST_IDLE;
                        finish_next = 1'b1;
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            finish_reg  <= 1'b0;
            cnt_reg     <= '0;
            failed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            finish_reg  <= finish_next;
            cnt_reg     <= cnt_next;
            failed_reg  <= failed_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg    <= idx_next;
        used_reg   <= used_next;
        low_reg    <= low_next;
        high_reg   <= high_next;
        mid_reg    <= mid_next;
        n_reg      <= n_next;
        nxt_reg    <= nxt_next;
        qp_reg     <= qp_next;
        carry_reg  <= carry_next;
        swap_reg   <= swap_next;
        open_reg   <= open_next;
        comp_reg   <= comp_next;
        st_reg     <= st_next;
        fnd_reg    <= fnd_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE) && !finish_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- sv/cpr_checker.sv -----
// Port-level checker of the code-point range-set engine and its bind statement.
module cpr_checker import cpr_pkg::*; #(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result word changed while stalled.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.ranges_held <= HELD_W'(MAX_RANGES))
        else $error("Range count exceeds capacity.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Second word taken while one is in work.");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> !m_data.status)
        else $error("Found reported with failing status.");

endmodule

bind code_point_range_set_engine_top cpr_checker #(.MAX_RANGES(MAX_RANGES)) u_cpr_checker (.*);
